// ===== src/sgpc_pkg.sv =====
// Shared widths, request codes and the vector entry type for the page coalescer.
// Used by the coalescer core, its port checker and the testbench; depends on nothing else.
package sgpc_pkg;

  localparam int unsigned CACHE_W    = 16;
  localparam int unsigned PHYS_W     = 40;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned LIMIT_W    = 17;
  localparam int unsigned PAGES_W    = 16;
  localparam int unsigned VTOTAL_W   = 6;
  localparam int unsigned SUM_W      = PHYS_W + 1;
  localparam int unsigned MAX_VECTORS_DEF = 32;

  localparam logic REQ_PAGE  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [PHYS_W-1:0]  base;
    logic [PAGES_W-1:0] len;
  } vec_t;

endpackage

// ===== src/scatter_gather_page_coalescer_core.sv =====
// Scatter-gather page coalescer core: sequencer, shared 41-bit add/compare unit,
// vector ring memory and output register. Depends on sgpc_pkg.
// A page joining an open transfer is accepted, makes four passes through the
// shared adder-comparator, then is decided; opening a transfer is accept, open.
// An emitted transfer reads memory, then loads the output, for each vector (a
// load can stall), then a refused page opens; an empty flush does nothing.
// Reset clears the sequencer and transfer state; the vector memory is not cleared.
module scatter_gather_page_coalescer_core #(
  parameter int unsigned MAX_VECTORS = sgpc_pkg::MAX_VECTORS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [sgpc_pkg::CACHE_W-1:0]        cache_id_i,
  input  logic [sgpc_pkg::PHYS_W-1:0]         phys_page_i,
  input  logic [sgpc_pkg::OFFSET_W-1:0]       file_offset_i,
  input  logic signed [sgpc_pkg::LIMIT_W-1:0] page_limit_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sgpc_pkg::PHYS_W-1:0]         vec_base_page_o,
  output logic [sgpc_pkg::PAGES_W-1:0]        vec_length_pages_o,
  output logic [sgpc_pkg::OFFSET_W-1:0]       start_offset_o,
  output logic [sgpc_pkg::PAGES_W-1:0]        total_pages_o,
  output logic [sgpc_pkg::VTOTAL_W-1:0]       vec_total_o,
  output logic                                last_o
);
  import sgpc_pkg::*;

  localparam int unsigned PTR_W = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int unsigned RING  = 2 ** PTR_W;
  localparam int unsigned CNT_W = $clog2(MAX_VECTORS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_OPEN = 3'd5;

  localparam logic [1:0] STEP_TOP_OFF = 2'd0;
  localparam logic [1:0] STEP_BOT_OFF = 2'd1;
  localparam logic [1:0] STEP_TOP_PHY = 2'd2;
  localparam logic [1:0] STEP_BOT_PHY = 2'd3;

  logic [2:0] state_q, state_d;
  logic [1:0] step_q, step_d;
  logic [3:0] adj_q, adj_d;

  // latched input item
  logic [CACHE_W-1:0]        cache_q;
  logic [PHYS_W-1:0]         phys_q;
  logic [OFFSET_W-1:0]       off_q;
  logic signed [LIMIT_W-1:0] lim_q;

  // open transfer
  logic                      open_q, open_d;
  logic                      pend_q, pend_d;
  logic [CACHE_W-1:0]        cur_cache_q, cur_cache_d;
  logic [OFFSET_W-1:0]       run_offset_q, run_offset_d;
  logic [PAGES_W-1:0]        run_pages_q, run_pages_d;
  logic signed [LIMIT_W-1:0] run_limit_q, run_limit_d;
  logic [CNT_W-1:0]          used_q, used_d;
  logic [PTR_W-1:0]          head_q, head_d;
  vec_t                      first_q, first_d;
  vec_t                      last_q, last_d;
  logic [CNT_W-1:0]          k_q, k_d;

  // vector ring
  vec_t             vec_mem [RING];
  vec_t             rdata_q;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  vec_t             mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic [PTR_W-1:0] tail;

  // shared adder-comparator
  logic [SUM_W-1:0] alu_a, alu_b, alu_t, alu_sum;
  logic             alu_eq;

  // output register
  logic                out_valid_q, out_valid_d;
  vec_t                out_vec_q;
  logic [OFFSET_W-1:0] out_off_q;
  logic [PAGES_W-1:0]  out_pages_q;
  logic [VTOTAL_W-1:0] out_vtot_q;
  logic                out_last_q;
  logic                out_load;

  logic accept_in, limit_hit, pages_full, room, join_ok;
  vec_t new_vec;

  assign accept_in = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign tail = head_q + PTR_W'(used_q - CNT_W'(1));
  assign new_vec = '{base: phys_q, len: PAGES_W'(1)};

  always_comb begin
    unique case (step_q)
      STEP_TOP_OFF: begin
        alu_a = SUM_W'(run_offset_q);
        alu_b = SUM_W'(run_pages_q);
        alu_t = SUM_W'(off_q);
      end
      STEP_BOT_OFF: begin
        alu_a = SUM_W'(run_offset_q);
        alu_b = '1;
        alu_t = SUM_W'(off_q);
      end
      STEP_TOP_PHY: begin
        alu_a = SUM_W'(last_q.base);
        alu_b = SUM_W'(last_q.len);
        alu_t = SUM_W'(phys_q);
      end
      default: begin
        alu_a = SUM_W'(first_q.base);
        alu_b = '1;
        alu_t = SUM_W'(phys_q);
      end
    endcase
    alu_sum = alu_a + alu_b;
    alu_eq  = (alu_sum == alu_t);
  end

  assign limit_hit  = !run_limit_q[LIMIT_W-1] &&
                      (LIMIT_W'(run_pages_q) >= $unsigned(run_limit_q));
  assign pages_full = &run_pages_q;
  assign room       = (used_q < CNT_W'(MAX_VECTORS));
  assign join_ok    = (cache_q == cur_cache_q) && !limit_hit && !pages_full;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    adj_d        = adj_q;
    open_d       = open_q;
    pend_d       = pend_q;
    cur_cache_d  = cur_cache_q;
    run_offset_d = run_offset_q;
    run_pages_d  = run_pages_q;
    run_limit_d  = run_limit_q;
    used_d       = used_q;
    head_d       = head_q;
    first_d      = first_q;
    last_d       = last_q;
    k_d          = k_q;
    mem_we       = 1'b0;
    mem_waddr    = head_q;
    mem_wdata    = new_vec;
    mem_re       = 1'b0;
    mem_raddr    = head_q + PTR_W'(k_q);
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          if (req_type_i == REQ_FLUSH) begin
            if (open_q) begin
              pend_d  = 1'b0;
              k_d     = '0;
              state_d = S_RD;
            end
          end else if (open_q) begin
            step_d  = STEP_TOP_OFF;
            state_d = S_CMP;
          end else begin
            state_d = S_OPEN;
          end
        end
      end
      S_CMP: begin
        adj_d[step_q] = alu_eq;
        step_d = step_q + 2'd1;
        if (step_q == STEP_BOT_PHY) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_IDLE;
        if (join_ok && adj_q[STEP_TOP_OFF] && adj_q[STEP_TOP_PHY]) begin
          // grow the last vector
          last_d.len = last_q.len + PAGES_W'(1);
          if (used_q == CNT_W'(1)) first_d = last_d;
          mem_we      = 1'b1;
          mem_waddr   = tail;
          mem_wdata   = last_d;
          run_pages_d = run_pages_q + PAGES_W'(1);
        end else if (join_ok && adj_q[STEP_BOT_OFF] && adj_q[STEP_BOT_PHY]) begin
          // grow the first vector downward
          first_d.base = phys_q;
          first_d.len  = first_q.len + PAGES_W'(1);
          if (used_q == CNT_W'(1)) last_d = first_d;
          mem_we       = 1'b1;
          mem_waddr    = head_q;
          mem_wdata    = first_d;
          run_offset_d = off_q;
          run_pages_d  = run_pages_q + PAGES_W'(1);
        end else if (join_ok && room && (adj_q[STEP_TOP_OFF] || adj_q[STEP_BOT_OFF])) begin
          mem_we      = 1'b1;
          used_d      = used_q + CNT_W'(1);
          run_pages_d = run_pages_q + PAGES_W'(1);
          if (adj_q[STEP_BOT_OFF]) begin
            // new vector at the front: step the ring head back
            head_d       = head_q - PTR_W'(1);
            mem_waddr    = head_d;
            first_d      = new_vec;
            run_offset_d = off_q;
          end else begin
            mem_waddr = tail + PTR_W'(1);
            last_d    = new_vec;
          end
        end else begin
          pend_d  = 1'b1;
          k_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          k_d      = k_q + CNT_W'(1);
          if (k_d == used_q) begin
            open_d  = 1'b0;
            state_d = pend_q ? S_OPEN : S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_OPEN: begin
        open_d       = 1'b1;
        pend_d       = 1'b0;
        cur_cache_d  = cache_q;
        run_offset_d = off_q;
        run_pages_d  = PAGES_W'(1);
        run_limit_d  = lim_q;
        used_d       = CNT_W'(1);
        head_d       = '0;
        first_d      = new_vec;
        last_d       = new_vec;
        mem_we       = 1'b1;
        mem_waddr    = '0;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= STEP_TOP_OFF;
      adj_q        <= '0;
      open_q       <= 1'b0;
      pend_q       <= 1'b0;
      cur_cache_q  <= '0;
      run_offset_q <= '0;
      run_pages_q  <= '0;
      run_limit_q  <= '0;
      used_q       <= '0;
      head_q       <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      adj_q        <= adj_d;
      open_q       <= open_d;
      pend_q       <= pend_d;
      cur_cache_q  <= cur_cache_d;
      run_offset_q <= run_offset_d;
      run_pages_q  <= run_pages_d;
      run_limit_q  <= run_limit_d;
      used_q       <= used_d;
      head_q       <= head_d;
      k_q          <= k_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cache_q <= cache_id_i;
      phys_q  <= phys_page_i;
      off_q   <= file_offset_i;
      lim_q   <= page_limit_i;
    end
    first_q <= first_d;
    last_q  <= last_d;
    if (out_load) begin
      out_vec_q   <= rdata_q;
      out_off_q   <= run_offset_q;
      out_pages_q <= run_pages_q;
      out_vtot_q  <= VTOTAL_W'(used_q);
      out_last_q  <= (k_q + CNT_W'(1) == used_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) vec_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= vec_mem[mem_raddr];
  end

  assign out_valid_o        = out_valid_q;
  assign vec_base_page_o    = out_vec_q.base;
  assign vec_length_pages_o = out_vec_q.len;
  assign start_offset_o     = out_off_q;
  assign total_pages_o      = out_pages_q;
  assign vec_total_o        = out_vtot_q;
  assign last_o             = out_last_q;

endmodule

// ===== src/sgpc_checker.sv =====
// Port-level checker for the page coalescer core, attached by bind.
// Depends on sgpc_pkg and scatter_gather_page_coalescer_core.
module sgpc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                req_type_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [sgpc_pkg::PHYS_W-1:0]         vec_base_page_o,
  input logic [sgpc_pkg::PAGES_W-1:0]        vec_length_pages_o,
  input logic [sgpc_pkg::PAGES_W-1:0]        total_pages_o,
  input logic                                last_o
);
  import sgpc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vec_base_page_o) &&
      $stable(vec_length_pages_o) && $stable(last_o))
    else $error("stalled result item changed");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (vec_length_pages_o != '0) && (total_pages_o != '0))
    else $error("result item with empty vector or transfer");

  a_len_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vec_length_pages_o <= total_pages_o)
    else $error("vector longer than its transfer");

  a_page_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_PAGE) |=> in_stall_o)
    else $error("page item accepted without busy cycle");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken while a transfer is still being emitted");

endmodule

bind scatter_gather_page_coalescer_core sgpc_checker u_sgpc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .req_type_i         (req_type_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .vec_base_page_o    (vec_base_page_o),
  .vec_length_pages_o (vec_length_pages_o),
  .total_pages_o      (total_pages_o),
  .last_o             (last_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for scatter_gather_page_coalescer_core: offers pages
// and flushes, predicts every emitted vector and checks it field by field.
// Depends on sgpc_pkg and the core; needs no other file.
module tb_top;
  import sgpc_pkg::*;

  localparam int NVEC        = MAX_VECTORS_DEF;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int RAND_ITEMS  = 500;

  typedef struct {
    logic                      req;
    logic [CACHE_W-1:0]        cache;
    logic [PHYS_W-1:0]         phys;
    logic [OFFSET_W-1:0]       offset;
    logic signed [LIMIT_W-1:0] limit;
    int unsigned               gap;
  } page_req_t;

  typedef struct {
    logic [PHYS_W-1:0]   base;
    logic [PAGES_W-1:0]  len;
    logic [OFFSET_W-1:0] start;
    logic [PAGES_W-1:0]  total;
    logic [VTOTAL_W-1:0] nvec;
    logic                last;
  } vec_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      req_type = REQ_PAGE;
  logic [CACHE_W-1:0]        cache_id = '0;
  logic [PHYS_W-1:0]         phys_page = '0;
  logic [OFFSET_W-1:0]       file_offset = '0;
  logic signed [LIMIT_W-1:0] page_limit = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [PHYS_W-1:0]         vec_base_page;
  logic [PAGES_W-1:0]        vec_length_pages;
  logic [OFFSET_W-1:0]       start_offset;
  logic [PAGES_W-1:0]        total_pages;
  logic [VTOTAL_W-1:0]       vec_total;
  logic                      last;

  scatter_gather_page_coalescer_core #(
    .MAX_VECTORS(NVEC)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .req_type_i         (req_type),
    .cache_id_i         (cache_id),
    .phys_page_i        (phys_page),
    .file_offset_i      (file_offset),
    .page_limit_i       (page_limit),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .vec_base_page_o    (vec_base_page),
    .vec_length_pages_o (vec_length_pages),
    .start_offset_o     (start_offset),
    .total_pages_o      (total_pages),
    .vec_total_o        (vec_total),
    .last_o             (last)
  );

  page_req_t   page_q[$];
  vec_result_t vec_q[$];
  page_req_t   cur_req;

  // coalescer state as the testbench sees it
  logic                      xfer_open = 1'b0;
  logic [CACHE_W-1:0]        xfer_cache = '0;
  logic [OFFSET_W-1:0]       xfer_offset = '0;
  logic [PAGES_W-1:0]        xfer_pages = '0;
  logic signed [LIMIT_W-1:0] xfer_limit = '0;
  int                        xfer_nvec = 0;
  logic [PHYS_W-1:0]         xfer_base[NVEC];
  logic [PAGES_W-1:0]        xfer_len[NVEC];

  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned idle_cnt = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned n_pushed = 0;
  int unsigned n_accepted = 0;
  int unsigned n_vectors = 0;
  int unsigned n_xfers = 0;
  int unsigned max_nvec = 0;
  int unsigned max_total = 0;
  int unsigned n_err = 0;
  int unsigned n_cycles = 0;

  task automatic report(string what);
    n_err++;
    if (n_err <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void open_transfer(page_req_t p);
    xfer_open = 1'b1;
    xfer_cache = p.cache;
    xfer_offset = p.offset;
    xfer_pages = PAGES_W'(1);
    xfer_limit = p.limit;
    xfer_base[0] = p.phys;
    xfer_len[0] = PAGES_W'(1);
    xfer_nvec = 1;
  endfunction

  function automatic void emit_transfer();
    vec_result_t r;
    for (int k = 0; k < xfer_nvec; k++) begin
      r.base = xfer_base[k];
      r.len = xfer_len[k];
      r.start = xfer_offset;
      r.total = xfer_pages;
      r.nvec = VTOTAL_W'(xfer_nvec);
      r.last = (k == xfer_nvec - 1);
      vec_q.push_back(r);
    end
    xfer_open = 1'b0;
  endfunction

  // Sums are taken wide and differences are guarded at zero, so nothing wraps at the field edges.
  function automatic bit try_extend(page_req_t p);
    int          lim;
    int          lastv;
    int          slot;
    bit          at_top;
    bit          at_bottom;
    logic [63:0] top_off;
    logic [63:0] top_phys;
    lim = int'(xfer_limit);
    if (p.cache != xfer_cache) return 1'b0;
    if (lim >= 0 && int'(xfer_pages) >= lim) return 1'b0;
    if (xfer_pages == '1) return 1'b0;
    lastv = xfer_nvec - 1;
    top_off = 64'(xfer_offset) + 64'(xfer_pages);
    top_phys = 64'(xfer_base[lastv]) + 64'(xfer_len[lastv]);
    at_top = (64'(p.offset) == top_off);
    at_bottom = (xfer_offset != 0) && (p.offset == xfer_offset - 32'd1);
    if (at_top && 64'(p.phys) == top_phys) begin
      xfer_len[lastv]++;
      xfer_pages++;
      return 1'b1;
    end
    if (at_bottom && xfer_base[0] != 0 && p.phys == xfer_base[0] - 40'd1) begin
      xfer_base[0] = p.phys;
      xfer_len[0]++;
      xfer_offset = p.offset;
      xfer_pages++;
      return 1'b1;
    end
    if ((at_top || at_bottom) && xfer_nvec < NVEC) begin
      if (at_bottom) begin
        for (int i = xfer_nvec; i > 0; i--) begin
          xfer_base[i] = xfer_base[i-1];
          xfer_len[i] = xfer_len[i-1];
        end
        xfer_offset = p.offset;
        slot = 0;
      end else begin
        slot = xfer_nvec;
      end
      xfer_base[slot] = p.phys;
      xfer_len[slot] = PAGES_W'(1);
      xfer_nvec++;
      xfer_pages++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void coalesce_page(page_req_t p);
    if (p.req == REQ_FLUSH) begin
      if (xfer_open) emit_transfer();
    end else if (!xfer_open) begin
      open_transfer(p);
    end else if (!try_extend(p)) begin
      emit_transfer();
      open_transfer(p);
    end
  endfunction

  function automatic logic [PHYS_W-1:0] rand_phys();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {PHYS_W{1'b1}} - PHYS_W'($urandom_range(0, 3));
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [OFFSET_W-1:0] rand_offset();
    case ($urandom_range(0, 9))
      0: return OFFSET_W'($urandom_range(0, 3));
      1: return {OFFSET_W{1'b1}} - OFFSET_W'($urandom_range(0, 3));
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [LIMIT_W-1:0] rand_limit();
    case ($urandom_range(0, 9))
      0, 1, 2: return -17'sd1;
      3: return '0;
      4: return 17'sh0FFFF;
      5, 6: return LIMIT_W'($urandom_range(1, 48));
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  task automatic push_page(logic [CACHE_W-1:0] c, logic [PHYS_W-1:0] ph,
                           logic [OFFSET_W-1:0] off, logic signed [LIMIT_W-1:0] lim);
    page_req_t p;
    p.req = REQ_PAGE;
    p.cache = c;
    p.phys = ph;
    p.offset = off;
    p.limit = lim;
    p.gap = tx_quiet ? 0 : $urandom_range(0, 11);
    page_q.push_back(p);
    n_pushed++;
  endtask

  // flush payload is don't-care: fill it with noise
  task automatic push_flush();
    page_req_t p;
    p.req = REQ_FLUSH;
    p.cache = 16'($urandom);
    p.phys = {8'($urandom), 32'($urandom)};
    p.offset = 32'($urandom);
    p.limit = LIMIT_W'($urandom);
    p.gap = tx_quiet ? 0 : $urandom_range(0, 11);
    page_q.push_back(p);
    n_pushed++;
  endtask

  // One well-formed run: pages extending the file range at either end, each one
  // physically adjacent by an adj_pct percent chance, with an occasional foreign cache or stray offset.
  task automatic build_run(int unsigned npages, int unsigned adj_pct);
    logic [CACHE_W-1:0]  c;
    logic [OFFSET_W-1:0] lo_off;
    logic [OFFSET_W-1:0] hi_off;
    logic [OFFSET_W-1:0] off;
    logic [PHYS_W-1:0]   lo_phys;
    logic [PHYS_W-1:0]   hi_phys;
    logic [PHYS_W-1:0]   ph;
    bit                  up;
    c = 16'($urandom);
    lo_off = rand_offset();
    hi_off = lo_off;
    lo_phys = rand_phys();
    hi_phys = lo_phys;
    push_page(c, lo_phys, lo_off, rand_limit());
    for (int i = 1; i < npages; i++) begin
      up = 1'($urandom_range(0, 1));
      if (hi_off == '1) up = 1'b0;
      if (lo_off == '0) up = 1'b1;
      if (up) begin
        hi_off++;
        off = hi_off;
        ph = ($urandom_range(1, 100) <= adj_pct) ? hi_phys + 40'd1 : rand_phys();
        hi_phys = ph;
      end else begin
        lo_off--;
        off = lo_off;
        ph = ($urandom_range(1, 100) <= adj_pct) ? lo_phys - 40'd1 : rand_phys();
        lo_phys = ph;
      end
      case ($urandom_range(0, 29))
        0: push_page(c ^ 16'(1 << $urandom_range(0, 15)), ph, off, rand_limit());
        1: push_page(c, ph, rand_offset(), rand_limit());
        default: push_page(c, ph, off, rand_limit());
      endcase
    end
    if ($urandom_range(0, 1)) push_flush();
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: present items from the queue, predict on each accepted one.
  always @(posedge clk_i) begin : drv
    bit free;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      idle_cnt <= 0;
    end else begin
      free = 1'b1;
      if (in_valid) begin
        if (!in_stall) begin
          coalesce_page(cur_req);
          n_accepted++;
        end else begin
          free = 1'b0;
        end
      end
      if (free) begin
        if (page_q.size() != 0 && idle_cnt >= page_q[0].gap) begin
          cur_req = page_q.pop_front();
          req_type <= cur_req.req;
          cache_id <= cur_req.cache;
          phys_page <= cur_req.phys;
          file_offset <= cur_req.offset;
          page_limit <= cur_req.limit;
          in_valid <= 1'b1;
          idle_cnt <= 0;
        end else begin
          in_valid <= 1'b0;
          idle_cnt <= idle_cnt + 1;
        end
      end
    end
  end

  // Monitor: check each accepted vector against the oldest prediction.
  always @(posedge clk_i) begin : mon
    vec_result_t want;
    int unsigned wait_n;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (vec_q.size() == 0) begin
          report($sformatf("vector base %h len %0d with nothing expected",
                           vec_base_page, vec_length_pages));
        end else begin
          want = vec_q.pop_front();
          if (vec_base_page !== want.base)
            report($sformatf("vec_base_page %h, expected %h", vec_base_page, want.base));
          if (vec_length_pages !== want.len)
            report($sformatf("vec_length_pages %0d, expected %0d", vec_length_pages, want.len));
          if (start_offset !== want.start)
            report($sformatf("start_offset %h, expected %h", start_offset, want.start));
          if (total_pages !== want.total)
            report($sformatf("total_pages %0d, expected %0d", total_pages, want.total));
          if (vec_total !== want.nvec)
            report($sformatf("vec_total %0d, expected %0d", vec_total, want.nvec));
          if (last !== want.last)
            report($sformatf("last %b, expected %b", last, want.last));
        end
        if (last === 1'b1) n_xfers++;
        if (32'(vec_total) > max_nvec) max_nvec = 32'(vec_total);
        if (32'(total_pages) > max_total) max_total = 32'(total_pages);
        // every 32 vectors, pick again between stalling and a clean stretch
        if (n_vectors % 32 == 31) rx_quiet = ($urandom_range(0, 2) == 0);
        n_vectors <= n_vectors + 1;
        wait_n = rx_quiet ? 0 : $urandom_range(0, 11);
      end else begin
        wait_n = (rx_wait != 0) ? rx_wait - 1 : 0;
      end
      rx_wait <= wait_n;
      out_stall <= (wait_n != 0) || (hold_left != 0);
    end
  end

  // Hold the output once for a long stretch so the core backs up into its input.
  always @(posedge clk_i) begin
    if (!hold_done && n_vectors >= 120) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : main
    int unsigned rand_start;
    int unsigned pick;

    // directed: field extremes, both ends, limits, cache change, no-wrap edges
    push_flush();
    push_page(16'hFFFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, -17'sd1);
    push_page(16'hFFFF, 40'hFF_FFFF_FFFE, 32'hFFFF_FFFE, 17'sh0FFFF);
    push_page(16'hFFFF, 40'h00_0000_0000, 32'hFFFF_FFFD, '0);
    push_flush();
    push_flush();
    push_page(16'h0000, 40'h0, 32'h0, '0);
    push_page(16'h0000, 40'h1, 32'h1, 17'sd3);
    push_page(16'h0000, 40'h2, 32'h2, -17'sd1);
    push_page(16'h0000, 40'h28, 32'h0, -17'sd1);
    push_page(16'h0000, 40'h3, 32'h3, 17'sh0FFFF);
    push_page(16'h0001, 40'h4, 32'h4, 17'sd2);
    push_page(16'h0001, 40'h3, 32'h3, '0);
    push_page(16'h0001, 40'h5, 32'h5, -17'sd1);
    push_page(16'h0001, 40'h0, 32'h4, '0);
    push_page(16'h0001, 40'h1_0000_0000, 32'h3, '0);
    push_page(16'h0001, 40'h6, 32'h6, '0);
    push_page(16'h0001, 40'h0, 32'h0, -17'sd1);
    push_page(16'h0001, 40'hFF_FFFF_FFFF, 32'h1, '0);
    push_page(16'h0001, 40'h0, 32'h2, '0);
    push_flush();

    // random: mostly well-formed runs, some long scattered ones, some noise
    rand_start = n_pushed;
    while (n_pushed - rand_start < RAND_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 2)
        push_page(16'($urandom), rand_phys(), rand_offset(), rand_limit());
      else if (pick == 2)
        push_flush();
      else if (pick < 6)
        build_run($urandom_range(30, 40), 5);
      else
        build_run($urandom_range(1, 12), 60);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (page_q.size() != 0 || in_valid || vec_q.size() != 0);
    repeat (100) @(negedge clk_i);

    if (vec_q.size() != 0) report($sformatf("%0d vector results never arrived", vec_q.size()));
    $display("requests accepted %0d, vectors checked %0d in %0d transfers",
             n_accepted, n_vectors, n_xfers);
    $display("widest transfer %0d vectors, longest transfer %0d pages", max_nvec, max_total);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sgpc_pkg.sv
src/scatter_gather_page_coalescer_core.sv
src/sgpc_checker.sv
tb/tb_top.sv
